[design/rfid_uart_frame_receiver_unit_macros.svh]
// Assertion macros for the RFID UART frame receiver
`ifndef RFID_UART_FRAME_RECEIVER_UNIT_MACROS_SVH
`define RFID_UART_FRAME_RECEIVER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define RFU_ASSERT_SAME(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("rfu assertion failed");
`define RFU_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("rfu assertion failed");
`else
`define RFU_ASSERT_SAME(label, clk_s, rstn_s, ante, cons)
`define RFU_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons)
`endif
`endif

[design/rfuart_pkg.sv]
// Shared constants for the RFID UART frame receiver
`default_nettype none
package rfuart_pkg;
  localparam int BYTE_W             = 8;
  localparam int CNT_W              = 5;
  localparam int IDX_W              = 5;
  localparam int OUT_W              = 32;
  localparam int CMD_MAX_LEN_DEF    = 30;
  localparam int AUTO_FRAME_LEN_DEF = 22;

  localparam logic [IDX_W-1:0]  IDX_RESET   = 5'd15;
  localparam logic [BYTE_W-1:0] AUTO_HEADER = 8'h04;
  localparam logic [BYTE_W-1:0] AUTO_SECOND = 8'h16;
  localparam logic [BYTE_W-1:0] SUM_GOOD    = 8'hFF;

  localparam logic [CNT_W-1:0] POS_LENGTH = 5'd1;
  localparam logic [CNT_W-1:0] POS_CODE   = 5'd2;
  localparam logic [CNT_W-1:0] POS_STATUS = 5'd4;
endpackage
`default_nettype wire

[design/rfid_uart_frame_receiver_unit.sv]
// RFID UART frame receiver: command-response and auto-read deframers
//
// Usage: each in_ transaction carries one received serial byte in in_tdata.
// Every byte produces exactly one out_ transaction, in the cycle after it is
// accepted. out_tlast is high when a command-response frame completed on
// that byte; out_tdata carries the checksum result, the latched code and
// status bytes, overflow and sticky error flags, and the auto-read tag
// result. Throughput is one byte per cycle unless out_tready stalls: both
// deframers update their counters and running XORs combinationally between
// the accepted byte and the result register. in_tready stays high while the
// result register is empty or being taken in the same cycle, so a stalled
// out_tready holds one result and blocks further input only after that.
// cfg_we writes the card byte position (reset 15); write it while idle.
// Reset (rst_n low, synchronous) clears both deframers, the sticky error
// and the result valid/done flags; the card byte position returns to 15.
`default_nettype none
`include "rfid_uart_frame_receiver_unit_macros.svh"
module rfid_uart_frame_receiver_unit #(
  parameter int CMD_MAX_LEN    = rfuart_pkg::CMD_MAX_LEN_DEF,
  parameter int AUTO_FRAME_LEN = rfuart_pkg::AUTO_FRAME_LEN_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [rfuart_pkg::BYTE_W-1:0]  in_tdata,   // [7:0] rx_byte
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [rfuart_pkg::OUT_W-1:0]        out_tdata,
  // [0] cmd_sum_ok, [8:1] cmd_code, [16:9] cmd_status, [17] cmd_overflow,
  // [18] cmd_error_sticky, [19] tag_valid, [27:20] tag_byte, [31:28] zero
  output logic                                out_tlast,  // cmd_done
  input  wire logic                           cfg_we,
  input  wire logic [rfuart_pkg::IDX_W-1:0]   cfg_wdata   // card_byte_index
);
  import rfuart_pkg::*;

  localparam logic [CNT_W-1:0] CMD_MAX  = CNT_W'(CMD_MAX_LEN);
  localparam logic [CNT_W-1:0] AUTO_LEN = CNT_W'(AUTO_FRAME_LEN);

  logic [IDX_W-1:0]  card_idx_r;
  logic [CNT_W-1:0]  cmd_cnt_r, cmd_cnt_nxt;
  logic [BYTE_W-1:0] cmd_len_r, cmd_len_nxt;
  logic [BYTE_W-1:0] cmd_xor_r, cmd_xor_nxt;
  logic [BYTE_W-1:0] cmd_code_r, cmd_code_nxt;
  logic [BYTE_W-1:0] cmd_stat_r, cmd_stat_nxt;
  logic              err_r, err_nxt;
  logic              auto_act_r, auto_act_nxt;
  logic [CNT_W-1:0]  auto_cnt_r, auto_cnt_nxt;
  logic [BYTE_W-1:0] auto_xor_r, auto_xor_nxt;
  logic [BYTE_W-1:0] auto_pick_r, auto_pick_nxt;

  logic              out_valid_r;
  logic              done_r, done_nxt;
  logic [OUT_W-1:0]  data_r, data_nxt;

  logic              accept;
  logic [BYTE_W-1:0] b;
  logic [BYTE_W-1:0] x;
  logic [CNT_W-1:0]  cnt_inc;
  logic              ovf, sum_ok, tag_valid;
  logic [BYTE_W-1:0] tag_byte;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;
  assign b         = in_tdata;

  always_comb begin
    cmd_len_nxt  = cmd_len_r;
    cmd_code_nxt = cmd_code_r;
    cmd_stat_nxt = cmd_stat_r;
    err_nxt      = err_r;
    ovf          = 1'b0;
    done_nxt     = 1'b0;
    sum_ok       = 1'b0;

    unique case (cmd_cnt_r)
      POS_LENGTH: cmd_len_nxt  = b;
      POS_CODE:   cmd_code_nxt = b;
      POS_STATUS: cmd_stat_nxt = b;
      default:    ;
    endcase

    x           = cmd_xor_r ^ b;
    cnt_inc     = cmd_cnt_r + CNT_W'(1);
    cmd_cnt_nxt = cnt_inc;
    if (cnt_inc >= CMD_MAX) begin
      cmd_cnt_nxt = '0;
      err_nxt     = 1'b1;
      ovf         = 1'b1;
    end
    if (cmd_len_nxt == {{(BYTE_W-CNT_W){1'b0}}, cmd_cnt_nxt}) begin
      cmd_cnt_nxt = '0;
      done_nxt    = 1'b1;
      sum_ok      = (x == SUM_GOOD);
    end
    cmd_xor_nxt = (done_nxt || ovf) ? '0 : x;

    auto_act_nxt  = auto_act_r;
    auto_cnt_nxt  = auto_cnt_r;
    auto_xor_nxt  = auto_xor_r;
    auto_pick_nxt = auto_pick_r;
    tag_valid     = 1'b0;
    tag_byte      = '0;

    if (auto_act_r) begin
      if (auto_cnt_r == POS_LENGTH && b != AUTO_SECOND) begin
        auto_act_nxt = 1'b0;
        auto_cnt_nxt = '0;
        auto_xor_nxt = '0;
      end else begin
        if (auto_cnt_r == card_idx_r) begin
          auto_pick_nxt = b;
        end
        auto_xor_nxt = auto_xor_r ^ b;
        auto_cnt_nxt = auto_cnt_r + CNT_W'(1);
        if (auto_cnt_nxt == AUTO_LEN) begin
          if (auto_xor_nxt == SUM_GOOD) begin
            tag_valid = 1'b1;
            tag_byte  = auto_pick_nxt;
          end
          auto_act_nxt = 1'b0;
          auto_cnt_nxt = '0;
          auto_xor_nxt = '0;
        end
      end
    end
    if (!auto_act_nxt && b == AUTO_HEADER) begin
      auto_act_nxt  = 1'b1;
      auto_pick_nxt = (card_idx_r == '0) ? b : '0;
      auto_xor_nxt  = b;
      auto_cnt_nxt  = CNT_W'(1);
    end

    data_nxt = {4'b0, tag_byte, tag_valid, err_nxt, ovf, cmd_stat_nxt, cmd_code_nxt, sum_ok};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      card_idx_r  <= IDX_RESET;
      cmd_cnt_r   <= '0;
      cmd_len_r   <= '0;
      cmd_xor_r   <= '0;
      cmd_code_r  <= '0;
      cmd_stat_r  <= '0;
      err_r       <= 1'b0;
      auto_act_r  <= 1'b0;
      auto_cnt_r  <= '0;
      auto_xor_r  <= '0;
      auto_pick_r <= '0;
      out_valid_r <= 1'b0;
      done_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        card_idx_r <= cfg_wdata;
      end
      if (accept) begin
        cmd_cnt_r   <= cmd_cnt_nxt;
        cmd_len_r   <= cmd_len_nxt;
        cmd_xor_r   <= cmd_xor_nxt;
        cmd_code_r  <= cmd_code_nxt;
        cmd_stat_r  <= cmd_stat_nxt;
        err_r       <= err_nxt;
        auto_act_r  <= auto_act_nxt;
        auto_cnt_r  <= auto_cnt_nxt;
        auto_xor_r  <= auto_xor_nxt;
        auto_pick_r <= auto_pick_nxt;
        done_r      <= done_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = done_r;

  `RFU_ASSERT_SAME(a_cmd_cnt_range, clk, rst_n, 1'b1, cmd_cnt_r < CMD_MAX)
  `RFU_ASSERT_SAME(a_auto_cnt_range, clk, rst_n, 1'b1, auto_cnt_r < AUTO_LEN)
  `RFU_ASSERT_SAME(a_auto_idle_clear, clk, rst_n, !auto_act_r, auto_cnt_r == '0)
  `RFU_ASSERT_SAME(a_tag_restart, clk, rst_n, out_valid_r && data_r[19], auto_cnt_r <= CNT_W'(1))
  `RFU_ASSERT_SAME(a_ovf_sticky, clk, rst_n, out_valid_r && data_r[17], data_r[18] && err_r)
  `RFU_ASSERT_NEXT(a_accept_result, clk, rst_n, accept, out_valid_r)
endmodule
`default_nettype wire

[tb/sv/tb_rfid_uart_frame_receiver_unit.sv]
// Self-checking testbench: serial byte stream in, deframer results checked per transaction
module tb_rfid_uart_frame_receiver_unit;
  import rfuart_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 170;
  localparam logic [CNT_W-1:0] AUTO_POS_SECOND = 5'd1;

  typedef struct packed {
    logic [3:0]        pad;
    logic [BYTE_W-1:0] tag_byte;
    logic              tag_valid;
    logic              error_sticky;
    logic              overflow;
    logic [BYTE_W-1:0] status;
    logic [BYTE_W-1:0] code;
    logic              sum_ok;
  } rx_word_t;

  typedef struct {
    rx_word_t word;
    logic     done;
  } rx_expect_t;

  class deframe_scoreboard;
    logic [IDX_W-1:0]  card_index;
    logic [CNT_W-1:0]  cmd_count;
    logic [BYTE_W-1:0] cmd_length;
    logic [BYTE_W-1:0] cmd_xor;
    logic [BYTE_W-1:0] cmd_code;
    logic [BYTE_W-1:0] cmd_status;
    logic              error_sticky;
    logic              auto_active;
    logic [CNT_W-1:0]  auto_count;
    logic [BYTE_W-1:0] auto_xor;
    logic [BYTE_W-1:0] auto_pick;
    rx_expect_t        expected_results[$];
    int                mismatches;

    function new();
      card_index   = IDX_RESET;
      cmd_count    = '0;
      cmd_length   = '0;
      cmd_xor      = '0;
      cmd_code     = '0;
      cmd_status   = '0;
      error_sticky = 1'b0;
      auto_active  = 1'b0;
      auto_count   = '0;
      auto_xor     = '0;
      auto_pick    = '0;
      mismatches   = 0;
    endfunction

    function void set_card_index(input logic [IDX_W-1:0] value);
      card_index = value;
    endfunction

    function void auto_take(input logic [BYTE_W-1:0] b);
      if (auto_count == card_index) auto_pick = b;
      auto_xor   = auto_xor ^ b;
      auto_count = auto_count + 1'b1;
    endfunction

    function void note_byte(input logic [BYTE_W-1:0] b);
      rx_expect_t        want;
      logic [BYTE_W-1:0] x;
      want.word = '0;
      want.done = 1'b0;

      case (cmd_count)
        POS_LENGTH: cmd_length = b;
        POS_CODE:   cmd_code   = b;
        POS_STATUS: cmd_status = b;
        default: ;
      endcase
      x = cmd_xor ^ b;
      cmd_count = cmd_count + 1'b1;
      if (cmd_count >= CMD_MAX_LEN_DEF) begin
        cmd_count = '0;
        error_sticky = 1'b1;
        want.word.overflow = 1'b1;
      end
      if (cmd_length == {3'b000, cmd_count}) begin
        cmd_count = '0;
        want.done = 1'b1;
        want.word.sum_ok = (x == SUM_GOOD);
      end
      cmd_xor = (want.done || want.word.overflow) ? '0 : x;

      if (auto_active) begin
        if (auto_count == AUTO_POS_SECOND && b != AUTO_SECOND) begin
          auto_active = 1'b0;
          auto_count  = '0;
          auto_xor    = '0;
        end else begin
          auto_take(b);
          if (auto_count == AUTO_FRAME_LEN_DEF) begin
            if (auto_xor == SUM_GOOD) begin
              want.word.tag_valid = 1'b1;
              want.word.tag_byte  = auto_pick;
            end
            auto_active = 1'b0;
            auto_count  = '0;
            auto_xor    = '0;
          end
        end
      end
      if (!auto_active && b == AUTO_HEADER) begin
        auto_active = 1'b1;
        auto_count  = '0;
        auto_xor    = '0;
        auto_pick   = '0;
        auto_take(b);
      end

      want.word.code         = cmd_code;
      want.word.status       = cmd_status;
      want.word.error_sticky = error_sticky;
      expected_results.push_back(want);
    endfunction

    task report(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
    endtask

    task compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) report($sformatf("%s expected %h got %h", name, want, got));
    endtask

    task check_result(input logic [OUT_W-1:0] data, input logic last);
      rx_word_t   got;
      rx_expect_t want;
      got = data;
      if (expected_results.size() == 0) begin
        report($sformatf("result %h with nothing expected", data));
        return;
      end
      want = expected_results.pop_front();
      compare_field("cmd_done", 8'(want.done), 8'(last));
      compare_field("cmd_sum_ok", 8'(want.word.sum_ok), 8'(got.sum_ok));
      compare_field("cmd_code", want.word.code, got.code);
      compare_field("cmd_status", want.word.status, got.status);
      compare_field("cmd_overflow", 8'(want.word.overflow), 8'(got.overflow));
      compare_field("cmd_error_sticky", 8'(want.word.error_sticky), 8'(got.error_sticky));
      compare_field("tag_valid", 8'(want.word.tag_valid), 8'(got.tag_valid));
      compare_field("tag_byte", want.word.tag_byte, got.tag_byte);
      compare_field("pad", 8'(want.word.pad), 8'(got.pad));
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [BYTE_W-1:0] in_tdata;   // [7:0] rx_byte
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;
  // [0] cmd_sum_ok, [8:1] cmd_code, [16:9] cmd_status, [17] cmd_overflow,
  // [18] cmd_error_sticky, [19] tag_valid, [27:20] tag_byte, [31:28] zero
  logic              out_tlast;  // cmd_done
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_wdata;  // card_byte_index

  deframe_scoreboard sb;
  logic [BYTE_W-1:0] burst_q[$];
  int                send_idle_pct;
  int                recv_idle_pct;
  int                hold_len;
  int                cycle_count;

  rfid_uart_frame_receiver_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[rfid_uart_frame_receiver_unit] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_len != 0) begin
        out_tready <= 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_len = 0;
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_byte(b);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.expected_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_card_index(input logic [IDX_W-1:0] value);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.set_card_index(value);
  endtask

  function automatic void build_burst();
    int                kind;
    int                len;
    logic [BYTE_W-1:0] acc;
    logic [BYTE_W-1:0] b;
    kind = $urandom_range(99);
    acc  = '0;
    burst_q.delete();
    if (kind < 35) begin
      len = ($urandom_range(3) == 0) ? $urandom_range(3, CMD_MAX_LEN_DEF - 1)
                                     : $urandom_range(5, 12);
      for (int i = 0; i < len - 1; i++) begin
        b = (i == 1) ? 8'(len) : 8'($urandom);
        burst_q.push_back(b);
        acc ^= b;
      end
      burst_q.push_back(($urandom_range(4) != 0) ? (acc ^ SUM_GOOD) : 8'($urandom));
    end else if (kind < 65) begin
      burst_q.push_back(AUTO_HEADER);
      burst_q.push_back(AUTO_SECOND);
      for (int i = 2; i < AUTO_FRAME_LEN_DEF - 2; i++) burst_q.push_back(8'($urandom));
      foreach (burst_q[i]) acc ^= burst_q[i];
      if ($urandom_range(9) == 0) begin
        // end on a good checksum that is also the header of the next frame
        burst_q.push_back(acc ^ SUM_GOOD ^ AUTO_HEADER);
        burst_q.push_back(AUTO_HEADER);
      end else begin
        b = 8'($urandom);
        burst_q.push_back(b);
        acc ^= b;
        burst_q.push_back(($urandom_range(4) != 0) ? (acc ^ SUM_GOOD) : 8'($urandom));
      end
    end else if (kind < 75) begin
      burst_q.push_back(AUTO_HEADER);
      b = 8'($urandom);
      if ($urandom_range(1) == 0) b = AUTO_HEADER;
      else if (b == AUTO_SECOND) b = '0;
      burst_q.push_back(b);
      repeat ($urandom_range(4)) burst_q.push_back(8'($urandom));
    end else if (kind < 85) begin
      burst_q.push_back(8'($urandom));
      case ($urandom_range(3))
        0: b = '0;
        1: b = 8'($urandom_range(CMD_MAX_LEN_DEF, 255));
        2: b = 8'($urandom_range(2));
        default: b = 8'($urandom);
      endcase
      burst_q.push_back(b);
      repeat (CMD_MAX_LEN_DEF + 2) burst_q.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 6)) burst_q.push_back(8'($urandom));
    end
  endfunction

  task automatic run_random(input int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      build_burst();
      foreach (burst_q[i]) send_byte(burst_q[i]);
      sent += burst_q.size();
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] directed[22];
    logic [IDX_W-1:0]  card_setting[6];
    sb          = new();
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    hold_len    = 0;
    cycle_count = 0;
    send_idle_pct = 27;
    recv_idle_pct = 83;
    directed = '{8'h00, 8'hFF, 8'h04, 8'h05, 8'h04, 8'h04, 8'h16, 8'hFF,
                 8'h00, 8'h06, 8'h3C, 8'h00, 8'h5A, 8'h66, 8'h80, 8'h7F,
                 8'h01, 8'h00, 8'h04, 8'h16, 8'hAA, 8'h55};
    card_setting = '{5'd0, 5'd21, 5'd31, 5'd22, 5'($urandom_range(1, 20)), IDX_RESET};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) send_byte(directed[i]);

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      if (p < 2) begin
        send_idle_pct = 27;
        recv_idle_pct = 83;
      end else if (p < 4) begin
        send_idle_pct = 83;
        recv_idle_pct = 27;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_card_index(card_setting[p]);
      if (p == 4) hold_len = 60;
      run_random(PHASE_ITEMS);
    end

    wait_drained();
    repeat (5) @(negedge clk);
    if (sb.mismatches == 0) $display("[rfid_uart_frame_receiver_unit] OK");
    else $display("[rfid_uart_frame_receiver_unit] ERROR");
    $finish;
  end
endmodule

[rfid_uart_frame_receiver_unit.f]
+incdir+design
design/rfuart_pkg.sv
design/rfid_uart_frame_receiver_unit.sv
tb/sv/tb_rfid_uart_frame_receiver_unit.sv
